// ===== hw/rtl/clp_pkg.sv =====
// Shared types and constants for the CR LF line keyword parser.
// Used by clp_regs, clp_ctrl, clp_dpath and crlf_line_keyword_parser.
package clp_pkg;

  localparam int NKEYS   = 6;
  localparam int KEY_W   = 40;
  localparam int PHASE_W = 7;

  localparam logic [PHASE_W-1:0] PHASE_MAX  = 7'd127;
  localparam logic [PHASE_W-1:0] NAME_START = 7'd6;
  localparam logic [2:0]         HEAD_LEN   = 3'd5;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  localparam logic [2:0] KIND_NOTICE  = 3'd0;
  localparam logic [2:0] KIND_FORWARD = 3'd1;
  localparam logic [2:0] KIND_REWIND  = 3'd2;
  localparam logic [2:0] KIND_HALT    = 3'd3;
  localparam logic [2:0] KIND_LIST    = 3'd4;
  localparam logic [2:0] KIND_SELECT  = 3'd5;
  localparam logic [2:0] KIND_UNKNOWN = 3'd6;

  localparam logic [1:0] MODE_FWD  = 2'd0;
  localparam logic [1:0] MODE_REW  = 2'd1;
  localparam logic [1:0] MODE_STOP = 2'd2;
  localparam logic [1:0] MODE_SPEC = 2'd3;

  localparam logic [1:0] SUFFIX_LAST = 2'd3;

  typedef logic [NKEYS-1:0][KEY_W-1:0] key_arr_t;

  typedef enum logic [1:0] {
    LOAD_SINGLE = 2'd0,
    LOAD_NAME   = 2'd1,
    LOAD_SUFFIX = 2'd2
  } load_sel_t;

  typedef struct packed {
    logic       take;
    logic [2:0] cnt;
    logic       rd_head;
    logic       cap_head;
    logic       match;
    logic       rd_idx;
    logic       cap_idx;
    logic       rd_name;
    logic       name_inc;
    logic       load;
    load_sel_t  load_sel;
  } cmd_t;

  typedef struct packed {
    logic       finish;
    logic [2:0] kind;
    logic       name_more;
    logic       out_free;
  } st_t;

  function automatic logic [7:0] suffix_char(input logic [1:0] i);
    logic [7:0] c;
    case (i)
      2'd0:    c = 8'h2E;
      2'd1:    c = 8'h42;
      2'd2:    c = 8'h4D;
      default: c = 8'h50;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/clp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module clp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/clp_regs.sv =====
// APB keyword register file: six 40-bit keywords at byte address 8*i.
// Depends on clp_pkg.
module clp_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [5:0]        paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready,
  output clp_pkg::key_arr_t keys
);

  logic [2:0] idx;

  assign idx    = paddr[5:3];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      keys <= '0;
    end else if (psel && penable && pwrite && (idx < 3'(clp_pkg::NKEYS))) begin
      keys[idx] <= pwdata[clp_pkg::KEY_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (idx < 3'(clp_pkg::NKEYS)) begin
      prdata = {{(64-clp_pkg::KEY_W){1'b0}}, keys[idx]};
    end
  end

endmodule

// ===== hw/rtl/clp_ctrl.sv =====
// Line-end sequencer: head read, match, index read, result emission.
// Depends on clp_pkg.
module clp_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  clp_pkg::st_t  st,
  output clp_pkg::cmd_t cmd
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_HEAD  = 8'b0000_0010,
    S_MATCH = 8'b0000_0100,
    S_IDX   = 8'b0000_1000,
    S_ONE   = 8'b0001_0000,
    S_NRD   = 8'b0010_0000,
    S_NWT   = 8'b0100_0000,
    S_SUF   = 8'b1000_0000
  } state_t;

  state_t     state, state_next;
  logic [2:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.cnt      = cnt;
    cmd.load_sel = clp_pkg::LOAD_SINGLE;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
        if (in_valid && st.finish) begin
          state_next = S_HEAD;
          cnt_next   = '0;
        end
      end
      S_HEAD: begin
        cmd.rd_head  = (cnt < clp_pkg::HEAD_LEN);
        cmd.cap_head = (cnt != 3'd0);
        cnt_next     = cnt + 3'd1;
        if (cnt == clp_pkg::HEAD_LEN) begin
          state_next = S_MATCH;
        end
      end
      S_MATCH: begin
        cmd.match  = 1'b1;
        cmd.rd_idx = 1'b1;
        state_next = S_IDX;
      end
      S_IDX: begin
        cmd.cap_idx = 1'b1;
        state_next  = (st.kind == clp_pkg::KIND_SELECT) ? S_NRD : S_ONE;
      end
      S_ONE: begin
        if (st.out_free) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_NRD: begin
        if (st.name_more) begin
          cmd.rd_name = 1'b1;
          state_next  = S_NWT;
        end else begin
          cnt_next   = '0;
          state_next = S_SUF;
        end
      end
      S_NWT: begin
        cmd.load_sel = clp_pkg::LOAD_NAME;
        if (st.out_free) begin
          cmd.load     = 1'b1;
          cmd.name_inc = 1'b1;
          state_next   = S_NRD;
        end
      end
      S_SUF: begin
        cmd.load_sel = clp_pkg::LOAD_SUFFIX;
        if (st.out_free) begin
          cmd.load = 1'b1;
          cnt_next = cnt + 3'd1;
          if (cnt[1:0] == clp_pkg::SUFFIX_LAST) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/clp_dpath.sv =====
// Framing counters, line store, keyword match, modes and output register.
// Depends on clp_pkg and clp_ram.
module clp_dpath #(
  parameter int LINE_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        rx_byte,
  input  clp_pkg::key_arr_t keys,
  input  clp_pkg::cmd_t     cmd,
  output clp_pkg::st_t      st,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        line_kind,
  output logic [7:0]        message_index,
  output logic [7:0]        name_char,
  output logic [1:0]        display_mode,
  output logic [1:0]        earlier_mode,
  output logic              run_end
);

  localparam int AW = $clog2(LINE_DEPTH);
  localparam int PW = clp_pkg::PHASE_W;

  logic [PW-1:0]    phase, len, ptr;
  logic             in_line;
  logic [39:0]      head;
  logic [2:0]       kind_q, kind_c;
  logic [7:0]       idx_q;
  logic [1:0]       mode_now, mode_before;
  logic             rd_ok;

  logic [PW-1:0]    pos, phase_inc, idx_pos;
  logic             framing_byte, store_ok;
  logic             re, rd_ok_c;
  logic [AW-1:0]    raddr;
  logic [7:0]       rdata, rbyte;

  assign pos       = phase - 7'd2;
  assign phase_inc = (phase < clp_pkg::PHASE_MAX) ? phase + 7'd1 : phase;
  assign store_ok  = ({1'b0, pos} < 8'(LINE_DEPTH));
  assign idx_pos   = len - 7'd3;
  // byte that does not go into the line (framing, or the restart CR)
  assign framing_byte = (phase == 7'd0) || (phase == 7'd1) ||
                        ((phase == 7'd2) && (rx_byte == clp_pkg::CH_CR));

  assign st.finish    = !framing_byte && in_line && (rx_byte == clp_pkg::CH_LF);
  assign st.kind      = kind_q;
  assign st.name_more = (({1'b0, ptr} + 8'd3) <= {1'b0, len}) &&
                        (({1'b0, ptr} + 8'd3) <= 8'(LINE_DEPTH));
  assign st.out_free  = !out_valid || out_ready;

  always_comb begin
    raddr   = ptr[AW-1:0];
    rd_ok_c = 1'b1;
    if (cmd.rd_head) begin
      raddr   = AW'(cmd.cnt);
      rd_ok_c = ({4'b0, cmd.cnt} < len);
    end else if (cmd.rd_idx) begin
      raddr   = idx_pos[AW-1:0];
      rd_ok_c = (len >= 7'd3) && ({1'b0, idx_pos} < 8'(LINE_DEPTH));
    end
  end

  assign re    = cmd.rd_head || cmd.rd_idx || cmd.rd_name;
  assign rbyte = rd_ok ? rdata : 8'h00;

  clp_ram #(.WIDTH(8), .DEPTH(LINE_DEPTH)) u_store (
    .clk   (clk),
    .we    (cmd.take && !framing_byte && in_line && store_ok),
    .waddr (pos[AW-1:0]),
    .wdata (rx_byte),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    kind_c = clp_pkg::KIND_UNKNOWN;
    for (int i = clp_pkg::NKEYS - 1; i >= 0; i--) begin
      if (keys[i] == head) begin
        kind_c = 3'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= '0;
      in_line     <= 1'b0;
      mode_now    <= clp_pkg::MODE_STOP;
      mode_before <= clp_pkg::MODE_STOP;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.take) begin
        if (phase == 7'd0) begin
          if (rx_byte == clp_pkg::CH_CR) begin
            phase <= 7'd1;
          end
        end else if (phase == 7'd1) begin
          if (rx_byte == clp_pkg::CH_LF) begin
            phase   <= 7'd2;
            in_line <= 1'b1;
          end else begin
            phase <= 7'd0;
          end
        end else if ((phase == 7'd2) && (rx_byte == clp_pkg::CH_CR)) begin
          phase   <= 7'd1;
          in_line <= 1'b0;
        end else if (in_line) begin
          if (rx_byte == clp_pkg::CH_LF) begin
            phase   <= '0;
            in_line <= 1'b0;
          end else begin
            phase <= phase_inc;
          end
        end
      end
      if (cmd.cap_idx) begin
        case (kind_q)
          clp_pkg::KIND_FORWARD: mode_now <= clp_pkg::MODE_FWD;
          clp_pkg::KIND_REWIND:  mode_now <= clp_pkg::MODE_REW;
          clp_pkg::KIND_HALT:    mode_now <= clp_pkg::MODE_STOP;
          clp_pkg::KIND_SELECT: begin
            mode_before <= mode_now;
            mode_now    <= clp_pkg::MODE_SPEC;
          end
          default: begin
          end
        endcase
      end
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && st.finish) begin
      len <= phase_inc - 7'd2;
    end
    if (re) begin
      rd_ok <= rd_ok_c;
    end
    if (cmd.cap_head) begin
      head <= {head[31:0], rbyte};
    end
    if (cmd.match) begin
      kind_q <= kind_c;
    end
    if (cmd.cap_idx) begin
      idx_q <= (kind_q == clp_pkg::KIND_NOTICE) ? rbyte : 8'h00;
      ptr   <= clp_pkg::NAME_START;
    end else if (cmd.name_inc) begin
      ptr <= ptr + 7'd1;
    end
    if (cmd.load) begin
      display_mode <= mode_now;
      earlier_mode <= mode_before;
      case (cmd.load_sel)
        clp_pkg::LOAD_NAME: begin
          line_kind     <= clp_pkg::KIND_SELECT;
          message_index <= 8'h00;
          name_char     <= rbyte;
          run_end       <= 1'b0;
        end
        clp_pkg::LOAD_SUFFIX: begin
          line_kind     <= clp_pkg::KIND_SELECT;
          message_index <= 8'h00;
          name_char     <= clp_pkg::suffix_char(cmd.cnt[1:0]);
          run_end       <= (cmd.cnt[1:0] == clp_pkg::SUFFIX_LAST);
        end
        default: begin
          line_kind     <= kind_q;
          message_index <= idx_q;
          name_char     <= 8'h00;
          run_end       <= 1'b1;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/crlf_line_keyword_parser.sv =====
// CR LF line keyword parser: takes one byte per cycle while framing a line.
// At the closing LF it stops input for the head walk, match and index read
// before the first result; a select line then sends its name chars and
// 4 suffix chars, at a rate set by the single read port of the line store.
// Reset (rst, synchronous): framing idle, modes stop, keywords zero; the
// line store is not cleared.
module crlf_line_keyword_parser #(
  parameter int LINE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] message_index, [15:8] name_char,
                                 // [17:16] display_mode, [19:18] earlier_mode
  output logic [2:0]  m_tuser,   // [2:0] line_kind
  output logic        m_tlast,   // run_end
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  clp_pkg::key_arr_t keys;
  clp_pkg::cmd_t     cmd;
  clp_pkg::st_t      st;
  logic [7:0]        message_index, name_char;
  logic [1:0]        display_mode, earlier_mode;

  clp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .keys    (keys)
  );

  clp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  clp_dpath #(.LINE_DEPTH(LINE_DEPTH)) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .rx_byte       (s_tdata),
    .keys          (keys),
    .cmd           (cmd),
    .st            (st),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .line_kind     (m_tuser),
    .message_index (message_index),
    .name_char     (name_char),
    .display_mode  (display_mode),
    .earlier_mode  (earlier_mode),
    .run_end       (m_tlast)
  );

  assign m_tdata = {4'b0, earlier_mode, display_mode, name_char, message_index};

  // input is held off while a select run is still being sent
  a_run_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> !s_tready)
    else $error("input accepted during a select run");

  a_single_ends_run: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != clp_pkg::KIND_SELECT)) |-> m_tlast)
    else $error("non-select line without run end");

  a_select_mode: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == clp_pkg::KIND_SELECT)) |->
      (m_tdata[17:16] == clp_pkg::MODE_SPEC))
    else $error("select result without specific mode");

endmodule

// ===== test/crlf_parser_checker.sv =====
`timescale 1ns / 1ps
// Result checker for crlf_line_keyword_parser: follows keyword writes and received
// bytes, predicts every result transfer and compares it with the result stream.
// Depends on clp_pkg for widths, characters, kinds and modes.
module crlf_parser_checker #(
  parameter int LINE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,
  input  logic [2:0]  m_tuser,
  input  logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending,
  output int          results_checked
);
  import clp_pkg::*;

  localparam int NAME_FIRST = int'(NAME_START);
  localparam int NAME_LAST  = NAME_FIRST + LINE_DEPTH - 9;
  localparam logic [31:0] FILE_EXT = ".BMP";

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] msg_index;
    logic [7:0] name_char;
    logic [1:0] mode_after;
    logic [1:0] mode_saved;
    logic       last;
  } line_result_t;

  logic [KEY_W-1:0]   keyword [NKEYS];
  logic [PHASE_W-1:0] phase;
  logic               open_line;
  logic [7:0]         line_buf [LINE_DEPTH];
  logic [1:0]         mode_cur;
  logic [1:0]         mode_prev;
  line_result_t       awaited [$];
  int                 fails = 0;
  int                 checked = 0;

  function automatic logic [7:0] line_byte(input int pos, input int len);
    int stored;
    stored = (len < LINE_DEPTH) ? len : LINE_DEPTH;
    if (pos < 0 || pos >= stored) return 8'h00;
    return line_buf[pos];
  endfunction

  task automatic queue_result(input logic [2:0] kind, input logic [7:0] idx,
                              input logic [7:0] ch, input logic last);
    line_result_t r;
    r.kind       = kind;
    r.msg_index  = idx;
    r.name_char  = ch;
    r.mode_after = mode_cur;
    r.mode_saved = mode_prev;
    r.last       = last;
    awaited.push_back(r);
  endtask

  task automatic close_line(input int len);
    logic [KEY_W-1:0] head;
    logic [2:0]       kind;
    logic             hit;
    int               last_pos;
    head = '0;
    for (int k = 0; k < HEAD_LEN; k++) head = {head[KEY_W-9:0], line_byte(k, len)};
    kind = KIND_UNKNOWN;
    hit  = 1'b0;
    for (int k = 0; k < NKEYS; k++) begin
      if (!hit && keyword[k] == head) begin
        kind = 3'(k);
        hit  = 1'b1;
      end
    end
    phase     = '0;
    open_line = 1'b0;
    case (kind)
      KIND_NOTICE: queue_result(KIND_NOTICE, line_byte(len - 3, len), 8'h00, 1'b1);
      KIND_SELECT: begin
        last_pos = len - 3;
        if (last_pos > NAME_LAST) last_pos = NAME_LAST;
        mode_prev = mode_cur;
        mode_cur  = MODE_SPEC;
        for (int p = NAME_FIRST; p <= last_pos; p++)
          queue_result(KIND_SELECT, 8'h00, line_byte(p, len), 1'b0);
        for (int s = 0; s < 4; s++)
          queue_result(KIND_SELECT, 8'h00, FILE_EXT[31 - 8*s -: 8], s == 3);
      end
      default: begin
        if (kind == KIND_FORWARD) mode_cur = MODE_FWD;
        else if (kind == KIND_REWIND) mode_cur = MODE_REW;
        else if (kind == KIND_HALT) mode_cur = MODE_STOP;
        queue_result(kind, 8'h00, 8'h00, 1'b1);
      end
    endcase
  endtask

  task automatic take_byte(input logic [7:0] b);
    int pos;
    if (phase == '0) begin
      if (b == CH_CR) phase = 7'd1;
    end else if (phase == 7'd1) begin
      if (b == CH_LF) begin
        phase     = 7'd2;
        open_line = 1'b1;
      end else begin
        phase = '0;
      end
    end else if (phase == 7'd2 && b == CH_CR) begin
      // CR right after the opening pair restarts framing
      phase     = 7'd1;
      open_line = 1'b0;
    end else if (open_line) begin
      pos = int'(phase) - 2;
      if (pos < LINE_DEPTH) line_buf[pos] = b;
      if (phase < PHASE_MAX) phase = phase + 7'd1;
      if (b == CH_LF) close_line(int'(phase) - 2);
    end
  endtask

  task automatic report_mismatch(input string what);
    fails++;
    if (fails <= 40) $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  always @(posedge clk) begin : watch
    line_result_t want;
    if (rst) begin
      foreach (keyword[i]) keyword[i] = '0;
      phase     = '0;
      open_line = 1'b0;
      mode_cur  = MODE_STOP;
      mode_prev = MODE_STOP;
      awaited.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[5:3] < NKEYS)
        keyword[paddr[5:3]] = pwdata[KEY_W-1:0];
      if (s_tvalid && s_tready) take_byte(s_tdata);
      if (m_tvalid && m_tready) begin
        if (awaited.size() == 0) begin
          report_mismatch($sformatf("result transfer with none expected, kind %0d", m_tuser));
        end else begin
          want = awaited.pop_front();
          checked++;
          if (m_tuser !== want.kind)
            report_mismatch($sformatf("line_kind %0d, want %0d", m_tuser, want.kind));
          if (m_tdata[7:0] !== want.msg_index)
            report_mismatch($sformatf("message_index %h, want %h",
                                      m_tdata[7:0], want.msg_index));
          if (m_tdata[15:8] !== want.name_char)
            report_mismatch($sformatf("name_char %h, want %h",
                                      m_tdata[15:8], want.name_char));
          if (m_tdata[17:16] !== want.mode_after)
            report_mismatch($sformatf("display_mode %0d, want %0d",
                                      m_tdata[17:16], want.mode_after));
          if (m_tdata[19:18] !== want.mode_saved)
            report_mismatch($sformatf("earlier_mode %0d, want %0d",
                                      m_tdata[19:18], want.mode_saved));
          if (m_tlast !== want.last)
            report_mismatch($sformatf("run_end %b, want %b", m_tlast, want.last));
        end
      end
    end
    fail_count      <= fails;
    pending         <= awaited.size();
    results_checked <= checked;
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for crlf_line_keyword_parser: drives modem bytes and keyword
// writes, gives the verdict. Depends on clp_pkg and crlf_parser_checker.
module tb_top;
  import clp_pkg::*;

  localparam int LINE_DEPTH  = 64;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_GAP   = 24;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = 6'd0;
  logic [63:0] pwdata = 64'd0;
  logic [63:0] prdata;
  logic        pready;

  int fail_count;
  int pending;
  int results_checked;
  int cycles;
  int lines = 0;
  int line_bytes = 0;
  int line_calls = 0;
  logic calm = 1'b0;
  logic [KEY_W-1:0] key_val [NKEYS];

  crlf_line_keyword_parser #(.LINE_DEPTH(LINE_DEPTH)) DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  crlf_parser_checker #(.LINE_DEPTH(LINE_DEPTH)) u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .fail_count(fail_count), .pending(pending), .results_checked(results_checked)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= calm || ($urandom_range(99) >= 10);
  end

  task automatic send_byte(input logic [7:0] b);
    while (!calm && $urandom_range(99) < 10) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic reg_write(input int idx, input logic [KEY_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 6'(idx * 8);
    pwdata  <= {24'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx < NKEYS) key_val[idx] = val;
    @(posedge clk);
  endtask

  function automatic logic [7:0] body_byte();
    logic [7:0] b;
    if ($urandom_range(15) == 0) return 8'h00;
    do b = 8'($urandom); while (b == CH_LF);
    return b;
  endfunction

  function automatic logic [KEY_W-1:0] printable_word();
    logic [KEY_W-1:0] w;
    for (int i = 0; i < 5; i++) w[8*i +: 8] = 8'($urandom_range(8'h20, 8'h7E));
    return w;
  endfunction

  task automatic send_frame(input string s);
    send_byte(CH_CR);
    send_byte(CH_LF);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    send_byte(CH_CR);
    send_byte(CH_LF);
    lines++;
    line_bytes += s.len() + 4;
  endtask

  // CR LF, optional restart pair, five head bytes, n body bytes, CR LF
  task automatic send_good(input logic [KEY_W-1:0] head, input int n, input logic restart);
    send_byte(CH_CR);
    send_byte(CH_LF);
    if (restart) begin
      send_byte(CH_CR);
      send_byte(CH_LF);
    end
    for (int i = 4; i >= 0; i--) send_byte(head[8*i +: 8]);
    repeat (n) send_byte(body_byte());
    send_byte(CH_CR);
    send_byte(CH_LF);
    lines++;
    line_bytes += n + 9;
  endtask

  task automatic random_line();
    int pick;
    int n;
    pick = $urandom_range(0, 9);
    n = ($urandom_range(0, 11) == 0) ? $urandom_range(50, 70) : $urandom_range(0, 10);
    if (pick <= 5) begin
      send_good(key_val[pick], n, $urandom_range(0, 9) == 0);
    end else if (pick <= 7) begin
      send_good(printable_word(), n, 1'b0);
    end else if (pick == 8) begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
    end else begin
      case ($urandom_range(0, 2))
        0: begin
          send_byte(CH_CR);
          send_byte(8'($urandom_range(8'h0B, 8'hFF)));
        end
        1: begin
          // unterminated line that swallows what follows
          send_byte(CH_CR);
          send_byte(CH_LF);
          repeat ($urandom_range(1, 4)) send_byte(body_byte());
        end
        default: begin
          send_byte(CH_CR);
          send_byte(CH_LF);
          send_byte(CH_LF);
        end
      endcase
    end
  endtask

  task automatic random_phase(input int min_bytes, input int min_lines);
    int start_bytes;
    int start_lines;
    start_bytes = line_bytes;
    start_lines = lines;
    while (line_bytes - start_bytes < min_bytes || lines - start_lines < min_lines) begin
      random_line();
      line_calls++;
      if (line_calls % 12 == 0) wait_drained();
    end
  endtask

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results still awaited", cycles, pending);
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // plain ASCII keywords
    reg_write(0, "+CMTI");
    reg_write(1, "PLAYF");
    reg_write(2, "REWND");
    reg_write(3, "STOPP");
    reg_write(4, "NAMES");
    reg_write(5, "SHOW:");
    send_frame("+CMTI: \"SM\",7");
    send_frame("PLAYF");
    send_frame("SHOW: cat");
    send_frame("REWND");
    send_frame("STOPP");
    send_frame("NAMES?");
    send_frame("SHOW:");
    send_frame("hello");
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_frame("PLAYF");
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_byte(CH_LF);
    send_byte("x");
    send_byte(CH_CR);
    send_byte("y");
    wait_drained();

    // extremes and ties; indexes past the last register are ignored
    reg_write(0, 40'h0A_0000_0000);
    reg_write(1, '0);
    reg_write(2, '1);
    reg_write(3, '1);
    reg_write(4, '0);
    reg_write(5, '1);
    reg_write(6, printable_word());
    reg_write(7, '0);
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_byte(CH_LF);
    send_good('0, 0, 1'b0);
    send_good('1, 3, 1'b0);
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_byte(8'h00);
    send_byte(CH_LF);
    calm <= 1'b1;
    random_phase(30, 2);
    wait_drained();
    calm <= 1'b0;

    // random printable keywords, long and saturating lines
    for (int i = 0; i < NKEYS; i++) reg_write(i, printable_word());
    send_good(key_val[5], 120, 1'b0);
    send_good(key_val[5], 1, 1'b0);
    random_phase(20, 2);
    wait_drained();

    $display("Sent %0d framed lines (%0d bytes) plus noise under three keyword sets,",
             lines, line_bytes);
    $display("with restarts, full store, short and long names; %0d results compared.",
             results_checked);
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
